FILE: rtl/swbe_pkg.sv
// ----------------------------------------------------------------------------
// swbe_pkg
// Shared types, constants and helpers of the sync word burst extractor.
// ----------------------------------------------------------------------------
package swbe_pkg;

  // default sizes
  localparam int unsigned HISTORY_BITS_DEF  = 64;
  localparam int unsigned MAX_CANDIDATE_DEF = 2048;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // register fields
  localparam int unsigned CAND_LEN_W  = 12;
  localparam int unsigned ERR_LIM_W   = 4;
  localparam int unsigned USER_PAT_W  = 64;
  localparam int unsigned USER_LEN_W  = 7;
  localparam int unsigned PAT_IDX_W   = 4;
  localparam int unsigned ERR_CNT_W   = 4;
  localparam int unsigned DELAY_W     = 6;

  // built-in word set
  localparam int unsigned BUILTIN_COUNT = 8;
  localparam int unsigned BUILTIN_LEN   = 32;

  localparam logic [ERR_LIM_W-1:0]  BUILTIN_LIMIT   = 4'd4;
  localparam logic [ERR_LIM_W-1:0]  LIMIT_CAP       = 4'd8;
  localparam logic [PAT_IDX_W-1:0]  USER_INDEX      = 4'd8;
  localparam logic [USER_LEN_W-1:0] USER_LEN_MIN    = 7'd8;
  localparam logic [USER_LEN_W-1:0] BUILTIN_LEN7    = 7'd32;
  localparam logic [DELAY_W-1:0]    BUILTIN_DELAY   = 6'd31;
  localparam logic [12:0]           CAND_MIN        = 13'd128;

  // reset values of the registers
  localparam logic [CAND_LEN_W-1:0] CAND_RESET      = 12'd480;
  localparam logic [ERR_LIM_W-1:0]  ERR_LIMIT_RESET = 4'd2;
  localparam logic [USER_LEN_W-1:0] USER_LEN_RESET  = 7'd8;

  // built-in words, first arriving bit in bit 31
  localparam logic [BUILTIN_LEN-1:0] BUILTIN_WORDS [BUILTIN_COUNT] = '{
    32'h170FF0F0, 32'h2FCC4C33, 32'h45D5AAAA, 32'h4DAAAA55,
    32'hD5ED7EBF, 32'hED2EC27C, 32'h873724E5, 32'h8F48241A
  };

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAND_LEN  = 3'd0,
    CFG_ERR_LIMIT = 3'd1,
    CFG_USER_MODE = 3'd2,
    CFG_USER_PAT  = 3'd3,
    CFG_USER_LEN  = 3'd4
  } cfg_idx_e;

  // scalar configuration seen by the datapath
  typedef struct packed {
    logic [CAND_LEN_W-1:0] cand_len;
    logic [ERR_LIM_W-1:0]  err_limit;
    logic                  user_mode;
    logic [USER_LEN_W-1:0] user_len;
  } cfg_t;

  // correlator verdict for the newest window
  typedef struct packed {
    logic                 hit;
    logic [PAT_IDX_W-1:0] pat_idx;
    logic [ERR_CNT_W-1:0] err;
    logic                 inv;
    logic [DELAY_W-1:0]   delay;
  } match_t;

  // one result item
  typedef struct packed {
    logic                 sync_hit;
    logic [PAT_IDX_W-1:0] pattern_index;
    logic [ERR_CNT_W-1:0] error_count;
    logic                 inverted;
    logic                 cand_bit;
    logic                 cand_last;
  } res_t;

  // number of set bits in a 64-bit word, summed as a balanced tree
  function automatic logic [6:0] popcnt64(input logic [63:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) begin
      s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

endpackage

FILE: rtl/swbe_if.sv
// ----------------------------------------------------------------------------
// swbe_in_if / swbe_out_if
// Valid/ready channels for the received bit stream and the burst results.
// ----------------------------------------------------------------------------
interface swbe_in_if;
  logic valid;
  logic ready;
  logic in_bit;

  modport source (output valid, output in_bit, input ready);
  modport sink   (input valid, input in_bit, output ready);
endinterface

interface swbe_out_if;
  logic                            valid;
  logic                            ready;
  logic                            sync_hit;
  logic [swbe_pkg::PAT_IDX_W-1:0]  pattern_index;
  logic [swbe_pkg::ERR_CNT_W-1:0]  error_count;
  logic                            inverted;
  logic                            cand_bit;
  logic                            cand_last;

  modport source (output valid, output sync_hit, output pattern_index,
                  output error_count, output inverted, output cand_bit,
                  output cand_last, input ready);
  modport sink   (input valid, input sync_hit, input pattern_index,
                  input error_count, input inverted, input cand_bit,
                  input cand_last, output ready);
endinterface

FILE: rtl/swbe_cfg.sv
// ----------------------------------------------------------------------------
// swbe_cfg
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module swbe_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [swbe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [swbe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output swbe_pkg::cfg_t                   cfg_o,
  output logic [swbe_pkg::USER_PAT_W-1:0]  user_pattern_o
);

  swbe_pkg::cfg_t                  cfg_q, cfg_d;
  logic [swbe_pkg::USER_PAT_W-1:0] pat_q, pat_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    pat_d = pat_q;
    if (cfg_we_i) begin
      unique case (swbe_pkg::cfg_idx_e'(cfg_idx_i))
        swbe_pkg::CFG_CAND_LEN:
          cfg_d.cand_len = cfg_data_i[swbe_pkg::CAND_LEN_W-1:0];
        swbe_pkg::CFG_ERR_LIMIT:
          cfg_d.err_limit = cfg_data_i[swbe_pkg::ERR_LIM_W-1:0];
        swbe_pkg::CFG_USER_MODE:
          cfg_d.user_mode = cfg_data_i[0];
        swbe_pkg::CFG_USER_PAT:
          pat_d = cfg_data_i[swbe_pkg::USER_PAT_W-1:0];
        swbe_pkg::CFG_USER_LEN:
          cfg_d.user_len = cfg_data_i[swbe_pkg::USER_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cand_len  <= swbe_pkg::CAND_RESET;
      cfg_q.err_limit <= swbe_pkg::ERR_LIMIT_RESET;
      cfg_q.user_mode <= 1'b0;
      cfg_q.user_len  <= swbe_pkg::USER_LEN_RESET;
      pat_q           <= '0;
    end else begin
      cfg_q <= cfg_d;
      pat_q <= pat_d;
    end
  end

  assign cfg_o          = cfg_q;
  assign user_pattern_o = pat_q;

endmodule

FILE: rtl/swbe_corr.sv
// ----------------------------------------------------------------------------
// swbe_corr
// Hamming-distance correlator of the newest window against the sync words.
// ----------------------------------------------------------------------------
module swbe_corr #(
  parameter int unsigned HistoryBits = swbe_pkg::HISTORY_BITS_DEF,
  localparam int unsigned FillW = $clog2(HistoryBits + 1)
) (
  input  logic [HistoryBits-1:0]           hist_i,
  input  logic [FillW-1:0]                 fill_i,
  input  swbe_pkg::cfg_t                   cfg_i,
  input  logic [swbe_pkg::USER_PAT_W-1:0]  user_pattern_i,
  output swbe_pkg::match_t                 match_o
);

  localparam logic [6:0] HistLen = 7'(HistoryBits);

  logic [6:0]  ulen;
  logic [63:0] pat_rev;
  logic [63:0] pat_aligned;
  logic [63:0] win_mask;
  logic [63:0] hist64;
  logic [6:0]  u_e0, u_e1, u_err;
  logic        u_inv;
  logic [3:0]  lim, blim;
  logic [6:0]  fill7;

  logic [5:0]  b_e0 [swbe_pkg::BUILTIN_COUNT];
  logic [5:0]  b_e1 [swbe_pkg::BUILTIN_COUNT];

  // user length clamped between USER_LEN_MIN and the history size
  always_comb begin
    ulen = cfg_i.user_len;
    if (ulen < swbe_pkg::USER_LEN_MIN) ulen = swbe_pkg::USER_LEN_MIN;
    if (ulen > HistLen) ulen = HistLen;
  end

  // user word reversed into window order and right-aligned
  always_comb begin
    for (int k = 0; k < 64; k++) begin
      pat_rev[63-k] = user_pattern_i[k];
    end
  end

  assign pat_aligned = pat_rev >> (7'd64 - ulen);
  assign win_mask    = ~({64{1'b1}} << ulen);
  assign hist64      = 64'(hist_i);
  assign fill7       = 7'(fill_i);

  // user word distance in both polarities
  assign u_e0  = swbe_pkg::popcnt64((hist64 ^ pat_aligned) & win_mask);
  assign u_e1  = ulen - u_e0;
  assign u_inv = (u_e1 < u_e0);
  assign u_err = u_inv ? u_e1 : u_e0;

  // error limits
  assign lim  = (cfg_i.err_limit > swbe_pkg::LIMIT_CAP) ? swbe_pkg::LIMIT_CAP
                                                        : cfg_i.err_limit;
  assign blim = (lim > swbe_pkg::BUILTIN_LIMIT) ? swbe_pkg::BUILTIN_LIMIT : lim;

  // built-in word distances
  always_comb begin
    for (int k = 0; k < swbe_pkg::BUILTIN_COUNT; k++) begin
      b_e0[k] = 6'(swbe_pkg::popcnt64({32'd0,
                  hist_i[swbe_pkg::BUILTIN_LEN-1:0] ^ swbe_pkg::BUILTIN_WORDS[k]}));
      b_e1[k] = 6'd32 - b_e0[k];
    end
  end

  // verdict, lowest built-in index wins
  always_comb begin
    match_o = '0;
    if (cfg_i.user_mode) begin
      match_o.pat_idx = swbe_pkg::USER_INDEX;
      match_o.delay   = 6'(ulen - 7'd1);
      match_o.err     = 4'(u_err);
      match_o.inv     = u_inv;
      match_o.hit     = (fill7 >= ulen) && (u_err <= 7'(lim));
    end else begin
      match_o.delay = swbe_pkg::BUILTIN_DELAY;
      for (int k = swbe_pkg::BUILTIN_COUNT - 1; k >= 0; k--) begin
        if ((fill7 >= swbe_pkg::BUILTIN_LEN7) &&
            (((b_e1[k] < b_e0[k]) ? b_e1[k] : b_e0[k]) <= 6'(blim))) begin
          match_o.hit     = 1'b1;
          match_o.pat_idx = 4'(k);
          match_o.inv     = (b_e1[k] < b_e0[k]);
          match_o.err     = 4'((b_e1[k] < b_e0[k]) ? b_e1[k] : b_e0[k]);
        end
      end
    end
  end

endmodule

FILE: rtl/sync_word_burst_extractor.sv
// ----------------------------------------------------------------------------
// sync_word_burst_extractor
// Frame sync hunt with a Hamming threshold and fixed-length burst capture.
// ----------------------------------------------------------------------------
// One received bit is taken per clock. Each accepted bit is shifted into the
// history and, while hunting, the newest window is checked against the sync
// words in the same cycle; any result lands in the output register at the
// next edge, and a new one may follow every cycle while input ready stays high.
// The rate is set by the single correlator stage (one popcount and compare
// per word) feeding the output register; input ready only drops while a
// finished result is held and the sink is not taking it. After a hit the
// block emits candidate_length bits starting at the sync word and does not
// hunt until the burst ends. No clearing pass follows reset.
module sync_word_burst_extractor #(
  parameter int unsigned HistoryBits  = swbe_pkg::HISTORY_BITS_DEF,
  parameter int unsigned MaxCandidate = swbe_pkg::MAX_CANDIDATE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  swbe_in_if.sink                          in_i,
  swbe_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [swbe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [swbe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned FillW = $clog2(HistoryBits + 1);
  localparam int unsigned HIdxW = $clog2(HistoryBits);
  localparam int unsigned CapW  = $clog2(MaxCandidate);
  localparam logic [FillW-1:0] FillMax = FillW'(HistoryBits);
  localparam logic [12:0]      CandMax = 13'(MaxCandidate);

  swbe_pkg::cfg_t                  cfg;
  logic [swbe_pkg::USER_PAT_W-1:0] user_pattern;
  swbe_pkg::match_t                match;

  logic [HistoryBits-1:0] hist_q, hist_d;
  logic [FillW-1:0]       fill_q, fill_d;
  logic [CapW-1:0]        cap_q, cap_d;
  logic [swbe_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic                   out_vld_q, out_vld_d;
  swbe_pkg::res_t         res_q, res_d;

  logic        in_fire;
  logic [12:0] clen;
  logic [CapW-1:0] run_rem;

  // configuration registers
  swbe_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_o          (cfg),
    .user_pattern_o (user_pattern)
  );

  // correlator on the updated history
  swbe_corr #(
    .HistoryBits (HistoryBits)
  ) u_corr (
    .hist_i         (hist_d),
    .fill_i         (fill_d),
    .cfg_i          (cfg),
    .user_pattern_i (user_pattern),
    .match_o        (match)
  );

  // handshake: take a request whenever the output register can be refilled
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // history and fill count after this bit
  assign hist_d = {hist_q[HistoryBits-2:0], in_i.in_bit};
  assign fill_d = (fill_q < FillMax) ? fill_q + FillW'(1) : fill_q;

  // burst length clamped when latched
  always_comb begin
    clen = 13'(cfg.cand_len);
    if (clen < swbe_pkg::CAND_MIN) clen = swbe_pkg::CAND_MIN;
    if (clen > CandMax) clen = CandMax;
  end
  assign run_rem = CapW'(clen - 13'd1);

  // capture control and result build
  always_comb begin
    cap_d     = cap_q;
    delay_d   = delay_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    if (out_o.ready) out_vld_d = 1'b0;
    if (in_fire) begin
      if (cap_q != '0) begin
        cap_d            = cap_q - CapW'(1);
        res_d            = '0;
        res_d.cand_bit   = hist_d[delay_q[HIdxW-1:0]];
        res_d.cand_last  = (cap_q == CapW'(1));
        out_vld_d        = 1'b1;
      end else if (match.hit) begin
        cap_d               = run_rem;
        delay_d             = match.delay;
        res_d.sync_hit      = 1'b1;
        res_d.pattern_index = match.pat_idx;
        res_d.error_count   = match.err;
        res_d.inverted      = match.inv;
        res_d.cand_bit      = hist_d[match.delay[HIdxW-1:0]];
        res_d.cand_last     = (run_rem == '0);
        out_vld_d           = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      fill_q    <= '0;
      cap_q     <= '0;
      delay_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      cap_q     <= cap_d;
      delay_q   <= delay_d;
      if (in_fire) begin
        hist_q <= hist_d;
        fill_q <= fill_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.sync_hit      = res_q.sync_hit;
  assign out_o.pattern_index = res_q.pattern_index;
  assign out_o.error_count   = res_q.error_count;
  assign out_o.inverted      = res_q.inverted;
  assign out_o.cand_bit      = res_q.cand_bit;
  assign out_o.cand_last     = res_q.cand_last;

endmodule
